### rtl/core/crpr_pkg.sv
// Shared constants and widths of the Catmull-Rom polyline resampler.
package crpr_pkg;

  localparam int POS_BITS  = 24;
  localparam int MAX_STEPS = 16;
  localparam int CFG_W     = 16;
  localparam int FLD_W     = 16;

  localparam logic [CFG_W-1:0] SEG_LEN_RESET = CFG_W'(600);

  localparam int DIF_W  = POS_BITS + 2;
  localparam int MUL_W  = (DIF_W > 33) ? DIF_W : 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int T_W    = 17;
  localparam int QUO_W  = 18;
  localparam int H_W    = 30;
  localparam int HF_W   = 52;
  localparam int ACC_W  = 60;
  localparam int D2_W   = 46;
  localparam int ABS_W  = 23;
  localparam int NL_W   = CFG_W + STEP_W;
  localparam int DIVC_W = 5;

  localparam logic [DIVC_W-1:0] DIV_TOP = DIVC_W'(17);

endpackage

### rtl/core/crpr_mul.sv
// Shared signed multiplier with a registered product.
module crpr_mul (
  input  logic                                clk,
  input  logic signed [crpr_pkg::MUL_W-1:0]   mul_a,
  input  logic signed [crpr_pkg::MUL_W-1:0]   mul_b,
  output logic signed [crpr_pkg::PROD_W-1:0]  mul_p
);
  import crpr_pkg::*;

  // The product is registered and is valid in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    mul_p <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

### rtl/core/catmull_rom_polyline_resampler.sv
// Top level of the Catmull-Rom polyline resampler: sequencer and datapath.
// The block takes one polyline row per input beat and, once the row after a
// segment is known (or at the last row), emits that segment as 1 to
// MAX_STEPS output beats: a cubic Hermite point with Catmull-Rom tangents and
// linearly interpolated half width and flow. After the last row that row is
// emitted alone with run_end set, and the stored rows are cleared. The block
// works on one input beat at a time and holds in_stall high until every
// result of that beat has been taken. All products go through one registered
// multiplier under a small sequencer, which finds the step count of a
// segment by trying up to MAX_STEPS steps, divides to set the t increment
// and then builds each output point, holding while out_stall is high.
// max_segment_length is written through cfg_we and cfg_wdata; the user
// must do so only while the block is idle, as the block itself does not
// enforce it. A value of zero acts as one.
module catmull_rom_polyline_resampler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [crpr_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [crpr_pkg::POS_BITS-1:0] in_pos_x,
  input  logic signed [crpr_pkg::POS_BITS-1:0] in_pos_y,
  input  logic signed [crpr_pkg::POS_BITS-1:0] in_pos_z,
  input  logic [crpr_pkg::FLD_W-1:0]          in_half_width,
  input  logic [crpr_pkg::FLD_W-1:0]          in_flow,
  input  logic                                in_last_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [crpr_pkg::POS_BITS-1:0] out_x,
  output logic signed [crpr_pkg::POS_BITS-1:0] out_y,
  output logic signed [crpr_pkg::POS_BITS-1:0] out_z,
  output logic [crpr_pkg::FLD_W-1:0]          out_half_width,
  output logic [crpr_pkg::FLD_W-1:0]          out_flow,
  output logic                                out_run_end
);
  import crpr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_ABS, ST_SQX, ST_SQY, ST_D2, ST_NSQ, ST_NCMP,
    ST_DIV, ST_T2, ST_T3, ST_H, ST_MUL, ST_ACC, ST_FIN, ST_OUT, ST_COMMIT
  } st_t;

  // Work still to do for the current input beat, in order.
  typedef enum logic [1:0] {JOB_A, JOB_B, JOB_ROW, JOB_DONE} job_t;

  localparam logic signed [ACC_W-1:0] RND28 = ACC_W'(2**27);
  localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(2**15);
  localparam logic signed [ACC_W-1:0] POS_MAXV = ACC_W'(2**(POS_BITS-1) - 1);
  localparam logic signed [ACC_W-1:0] POS_MINV = -POS_MAXV - ACC_W'(1);
  localparam logic signed [HF_W-1:0]  RND20 = HF_W'(2**19);
  localparam logic signed [HF_W-1:0]  RND21 = HF_W'(2**20);
  localparam logic [DIF_W-1:0]        BIG_LIM = DIF_W'(2**22);

  st_t  state_r;
  job_t job_r;

  logic                       out_valid_r;
  logic                       run_end_r;
  logic signed [POS_BITS-1:0] out_pos_r [3];
  logic [FLD_W-1:0]           out_hw_r;
  logic [FLD_W-1:0]           out_fl_r;

  logic [CFG_W-1:0]           seg_len_r;
  logic signed [POS_BITS-1:0] win_r [3][3];
  logic [FLD_W-1:0]           wwid_r [2];
  logic [FLD_W-1:0]           wflo_r [2];
  logic [1:0]                 rows_seen_r;

  logic signed [POS_BITS-1:0] cur_r [3];
  logic [FLD_W-1:0]           cur_w_r;
  logic [FLD_W-1:0]           cur_f_r;
  logic                       last_r;

  logic signed [POS_BITS-1:0] sp_r [4][3];
  logic [FLD_W-1:0]           wa_r, wb_r, fa_r, fb_r;

  logic [ABS_W-1:0]           ax_r, ay_r;
  logic                       big_r;
  logic [D2_W-1:0]            d2_r;
  logic [STEP_W-1:0]          n_r;
  logic [STEP_W-1:0]          s_r;
  logic [NL_W-1:0]            nl_r;
  logic [DIVC_W-1:0]          div_cnt_r;
  logic [STEP_W:0]            rem_r;
  logic [QUO_W-1:0]           quot_r;
  logic [T_W-1:0]             tq_r;
  logic [STEP_W:0]            tr_r;
  logic [31:0]                t2_r;
  logic signed [H_W-1:0]      h01_r, h10_r, h11_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [1:0]                 axis_r;
  logic [1:0]                 term_r;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;

  crpr_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  // Per-axis differences of the segment rows.
  logic [1:0]               ai;
  logic signed [DIF_W-1:0]  d21, d20, d31, dxs, dys;
  logic [DIF_W-1:0]         adx, ady;
  logic signed [FLD_W:0]    dw, df;
  logic [CFG_W-1:0]         len;
  logic [STEP_W+1:0]        dvs, remsh, tsum;
  logic [STEP_W+1:0]        rem_sub, tr_sub;
  logic                     div_bit;
  logic signed [HF_W-1:0]   t3e, t2e, t1e, h01f, h10f, h11f;
  logic signed [ACC_W-1:0]  prod_s, acc_sum, rnd_v, pos_v, lerp_base, lerp_v;
  logic signed [POS_BITS-1:0] pos_sat;
  logic                     in_acc, seg_last_pt;
  job_t                     first_job;

  always_comb begin
    ai  = (axis_r == 2'd3) ? 2'd0 : axis_r;
    d21 = DIF_W'(sp_r[2][ai]) - DIF_W'(sp_r[1][ai]);
    d20 = DIF_W'(sp_r[2][ai]) - DIF_W'(sp_r[0][ai]);
    d31 = DIF_W'(sp_r[3][ai]) - DIF_W'(sp_r[1][ai]);
    dxs = DIF_W'(sp_r[2][0]) - DIF_W'(sp_r[1][0]);
    dys = DIF_W'(sp_r[2][1]) - DIF_W'(sp_r[1][1]);
    adx = (dxs < 0) ? DIF_W'(-dxs) : DIF_W'(dxs);
    ady = (dys < 0) ? DIF_W'(-dys) : DIF_W'(dys);
    dw  = $signed({1'b0, wb_r}) - $signed({1'b0, wa_r});
    df  = $signed({1'b0, fb_r}) - $signed({1'b0, fa_r});
    len = (seg_len_r == '0) ? CFG_W'(1) : seg_len_r;

    dvs     = {1'b0, n_r, 1'b0};
    div_bit = (div_cnt_r == DIV_TOP);
    remsh   = {rem_r, div_bit};
    rem_sub = remsh - dvs;
    tsum    = {1'b0, tr_r} + {1'b0, rem_r};
    tr_sub  = tsum - dvs;

    // Hermite basis from t, t^2 and t^3, all taken to Q48 and rounded.
    t3e  = $signed({4'b0, mul_p[47:0]});
    t2e  = $signed({4'b0, t2_r, 16'b0});
    t1e  = $signed({3'b0, tq_r, 32'b0});
    h01f = (HF_W'(3) * t2e - HF_W'(2) * t3e + RND20) >>> 20;
    h10f = (t3e - HF_W'(2) * t2e + t1e + RND21) >>> 21;
    h11f = (t3e - t2e + RND21) >>> 21;

    prod_s    = ACC_W'(mul_p);
    acc_sum   = (term_r == 2'd0) ? prod_s : acc_r + prod_s;
    rnd_v     = (acc_r + RND28) >>> 28;
    pos_v     = rnd_v + ACC_W'(sp_r[1][ai]);
    if (pos_v > POS_MAXV) begin
      pos_sat = POS_BITS'(POS_MAXV);
    end else if (pos_v < POS_MINV) begin
      pos_sat = POS_BITS'(POS_MINV);
    end else begin
      pos_sat = POS_BITS'(pos_v);
    end
    lerp_base = (term_r == 2'd0) ? ACC_W'($signed({1'b0, wa_r}))
                                 : ACC_W'($signed({1'b0, fa_r}));
    lerp_v    = ((prod_s + RND16) >>> 16) + lerp_base;

    in_acc      = in_valid && !in_stall;
    seg_last_pt = (STEP_W'(s_r + STEP_W'(1)) == n_r);

    if (rows_seen_r >= 2'd2) begin
      first_job = JOB_A;
    end else if (in_last_row && rows_seen_r >= 2'd1) begin
      first_job = JOB_B;
    end else if (in_last_row) begin
      first_job = JOB_ROW;
    end else begin
      first_job = JOB_DONE;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQX: begin
        mul_a = MUL_W'($signed({1'b0, ax_r}));
        mul_b = MUL_W'($signed({1'b0, ax_r}));
      end
      ST_SQY: begin
        mul_a = MUL_W'($signed({1'b0, ay_r}));
        mul_b = MUL_W'($signed({1'b0, ay_r}));
      end
      ST_NSQ: begin
        mul_a = MUL_W'($signed({1'b0, nl_r}));
        mul_b = MUL_W'($signed({1'b0, nl_r}));
      end
      ST_T2: begin
        mul_a = MUL_W'($signed({1'b0, tq_r}));
        mul_b = MUL_W'($signed({1'b0, tq_r}));
      end
      ST_T3: begin
        mul_a = MUL_W'($signed({1'b0, mul_p[31:0]}));
        mul_b = MUL_W'($signed({1'b0, tq_r}));
      end
      ST_MUL: begin
        if (axis_r == 2'd3) begin
          mul_a = (term_r == 2'd0) ? MUL_W'(dw) : MUL_W'(df);
          mul_b = MUL_W'($signed({1'b0, tq_r}));
        end else begin
          case (term_r)
            2'd0: begin
              mul_a = MUL_W'(h01_r);
              mul_b = MUL_W'(d21);
            end
            2'd1: begin
              mul_a = MUL_W'(h10_r);
              mul_b = MUL_W'(d20);
            end
            default: begin
              mul_a = MUL_W'(h11_r);
              mul_b = MUL_W'(d31);
            end
          endcase
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= JOB_DONE;
      out_valid_r <= 1'b0;
      rows_seen_r <= 2'd0;
      seg_len_r   <= SEG_LEN_RESET;
      for (int i = 0; i < 3; i++) begin
        for (int a = 0; a < 3; a++) begin
          win_r[i][a] <= '0;
        end
      end
      for (int i = 0; i < 2; i++) begin
        wwid_r[i] <= '0;
        wflo_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        seg_len_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cur_r[0] <= in_pos_x;
            cur_r[1] <= in_pos_y;
            cur_r[2] <= in_pos_z;
            cur_w_r  <= in_half_width;
            cur_f_r  <= in_flow;
            last_r   <= in_last_row;
            job_r    <= first_job;
            state_r  <= ST_DISP;
          end
        end
        ST_DISP: begin
          case (job_r)
            JOB_A: begin
              sp_r[0] <= (rows_seen_r >= 2'd3) ? win_r[0] : win_r[1];
              sp_r[1] <= win_r[1];
              sp_r[2] <= win_r[2];
              sp_r[3] <= cur_r;
              wa_r    <= wwid_r[0];
              wb_r    <= wwid_r[1];
              fa_r    <= wflo_r[0];
              fb_r    <= wflo_r[1];
              state_r <= ST_ABS;
            end
            JOB_B: begin
              sp_r[0] <= (rows_seen_r >= 2'd2) ? win_r[1] : win_r[2];
              sp_r[1] <= win_r[2];
              sp_r[2] <= cur_r;
              sp_r[3] <= cur_r;
              wa_r    <= wwid_r[1];
              wb_r    <= cur_w_r;
              fa_r    <= wflo_r[1];
              fb_r    <= cur_f_r;
              state_r <= ST_ABS;
            end
            JOB_ROW: begin
              out_pos_r   <= cur_r;
              out_hw_r    <= cur_w_r;
              out_fl_r    <= cur_f_r;
              run_end_r   <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= ST_OUT;
            end
            default: begin
              state_r <= ST_COMMIT;
            end
          endcase
        end
        ST_ABS: begin
          ax_r    <= adx[ABS_W-1:0];
          ay_r    <= ady[ABS_W-1:0];
          big_r   <= (adx > BIG_LIM) || (ady > BIG_LIM);
          state_r <= ST_SQX;
        end
        ST_SQX: begin
          if (big_r) begin
            n_r       <= STEP_W'(MAX_STEPS);
            div_cnt_r <= DIV_TOP;
            rem_r     <= '0;
            quot_r    <= '0;
            state_r   <= ST_DIV;
          end else begin
            state_r <= ST_SQY;
          end
        end
        ST_SQY: begin
          d2_r    <= mul_p[D2_W-1:0];
          state_r <= ST_D2;
        end
        ST_D2: begin
          d2_r    <= d2_r + mul_p[D2_W-1:0];
          n_r     <= STEP_W'(1);
          nl_r    <= NL_W'(len);
          state_r <= ST_NSQ;
        end
        ST_NSQ: begin
          state_r <= ST_NCMP;
        end
        ST_NCMP: begin
          if (n_r < STEP_W'(MAX_STEPS) && mul_p[D2_W-1:0] < d2_r) begin
            n_r     <= n_r + STEP_W'(1);
            nl_r    <= nl_r + NL_W'(len);
            state_r <= ST_NSQ;
          end else begin
            div_cnt_r <= DIV_TOP;
            rem_r     <= '0;
            quot_r    <= '0;
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Restoring division of 2^17 by 2n, one quotient bit a cycle.
          if (remsh >= dvs) begin
            rem_r  <= rem_sub[STEP_W:0];
            quot_r <= {quot_r[QUO_W-2:0], 1'b1};
          end else begin
            rem_r  <= remsh[STEP_W:0];
            quot_r <= {quot_r[QUO_W-2:0], 1'b0};
          end
          if (div_cnt_r == '0) begin
            s_r     <= '0;
            tq_r    <= '0;
            tr_r    <= {1'b0, n_r};
            state_r <= ST_T2;
          end else begin
            div_cnt_r <= div_cnt_r - DIVC_W'(1);
          end
        end
        ST_T2: begin
          state_r <= ST_T3;
        end
        ST_T3: begin
          t2_r    <= mul_p[31:0];
          state_r <= ST_H;
        end
        ST_H: begin
          h01_r   <= H_W'(h01f);
          h10_r   <= H_W'(h10f);
          h11_r   <= H_W'(h11f);
          axis_r  <= 2'd0;
          term_r  <= 2'd0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (axis_r == 2'd3) begin
            if (term_r == 2'd0) begin
              out_hw_r <= lerp_v[FLD_W-1:0];
              term_r   <= 2'd1;
              state_r  <= ST_MUL;
            end else begin
              out_fl_r    <= lerp_v[FLD_W-1:0];
              run_end_r   <= seg_last_pt && job_r == JOB_A && !last_r;
              out_valid_r <= 1'b1;
              state_r     <= ST_OUT;
            end
          end else begin
            acc_r <= acc_sum;
            if (term_r == 2'd2) begin
              state_r <= ST_FIN;
            end else begin
              term_r  <= term_r + 2'd1;
              state_r <= ST_MUL;
            end
          end
        end
        ST_FIN: begin
          out_pos_r[ai] <= pos_sat;
          axis_r        <= axis_r + 2'd1;
          term_r        <= 2'd0;
          state_r       <= ST_MUL;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (job_r == JOB_ROW) begin
              state_r <= ST_COMMIT;
            end else if (!seg_last_pt) begin
              s_r <= s_r + STEP_W'(1);
              if (tsum >= dvs) begin
                tr_r <= tr_sub[STEP_W:0];
                tq_r <= tq_r + quot_r[T_W-1:0] + T_W'(1);
              end else begin
                tr_r <= tsum[STEP_W:0];
                tq_r <= tq_r + quot_r[T_W-1:0];
              end
              state_r <= ST_T2;
            end else begin
              job_r   <= (job_r == JOB_A) ? (last_r ? JOB_B : JOB_DONE) : JOB_ROW;
              state_r <= ST_DISP;
            end
          end
        end
        ST_COMMIT: begin
          if (last_r) begin
            for (int i = 0; i < 3; i++) begin
              for (int a = 0; a < 3; a++) begin
                win_r[i][a] <= '0;
              end
            end
            for (int i = 0; i < 2; i++) begin
              wwid_r[i] <= '0;
              wflo_r[i] <= '0;
            end
            rows_seen_r <= 2'd0;
          end else begin
            win_r[0]  <= win_r[1];
            win_r[1]  <= win_r[2];
            win_r[2]  <= cur_r;
            wwid_r[0] <= wwid_r[1];
            wwid_r[1] <= cur_w_r;
            wflo_r[0] <= wflo_r[1];
            wflo_r[1] <= cur_f_r;
            if (rows_seen_r != 2'd3) begin
              rows_seen_r <= rows_seen_r + 2'd1;
            end
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_x          = out_pos_r[0];
  assign out_y          = out_pos_r[1];
  assign out_z          = out_pos_r[2];
  assign out_half_width = out_hw_r;
  assign out_flow       = out_fl_r;
  assign out_run_end    = run_end_r;

`ifndef ASSERT_OFF
  // An accepted beat keeps the input side closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // The step count stays within its range while points are produced.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_T2) |-> (n_r >= STEP_W'(1) && n_r <= STEP_W'(MAX_STEPS)))
    else $error("step count out of range");

  // The running remainder of t stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_T2) |-> ({1'b0, tr_r} < dvs))
    else $error("t remainder not reduced");

  // No result is valid right after a beat with run_end set has been taken.
  a_run_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_end && !out_stall) |=> !out_valid)
    else $error("result after run end");
`endif

endmodule
